// ===== rtl/core/delayed_feedback_plant_step_top_assert.svh =====
// Assertion macros shared by the plant step checker.
`ifndef DELAYED_FEEDBACK_PLANT_STEP_TOP_ASSERT_SVH
`define DELAYED_FEEDBACK_PLANT_STEP_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define DFPS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dfps check failed");

// Next-cycle implication, disabled while reset is high.
`define DFPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dfps check failed");

`endif

// ===== rtl/core/dfps_pkg.sv =====
// Shared types and constants of the delayed feedback plant step block.
`default_nettype none
package dfps_pkg;

   localparam int FRAC_BITS = 24;
   localparam int VAL_W     = 32;
   localparam int TICK_W    = 16;
   localparam int DELAY_W   = 8;
   localparam int DEV_W     = 31;
   localparam int ADDR_W    = 5;
   localparam int DATA_W    = 32;

   localparam logic signed [VAL_W-1:0] Q_ONE       = 32'sh0100_0000;
   localparam logic [DEV_W-1:0]        SETTLE_BAND = 31'd335544;
   localparam logic [DEV_W-1:0]        DEV_MAX     = 31'h7FFF_FFFF;
   localparam logic [TICK_W-1:0]       TICK_MAX    = 16'hFFFF;

   localparam logic signed [VAL_W-1:0] RST_LOOP_GAIN     = 32'sd335544;
   localparam logic signed [VAL_W-1:0] RST_VELOCITY_COEF = 32'sd335544;
   localparam logic signed [VAL_W-1:0] RST_POSITION_COEF = 32'sd167772;
   localparam logic signed [VAL_W-1:0] RST_TIME_STEP     = 32'sd167772;
   localparam logic [DELAY_W-1:0]      RST_DELAY_TICKS   = 8'd10;
   localparam logic [TICK_W-1:0]       RST_GOAL_START    = 16'd10;

   typedef enum logic [2:0] {
      REG_LOOP_GAIN     = 3'd0,
      REG_VELOCITY_COEF = 3'd1,
      REG_POSITION_COEF = 3'd2,
      REG_TIME_STEP     = 3'd3,
      REG_DELAY_TICKS   = 3'd4,
      REG_GOAL_START    = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] loop_gain;
      logic signed [VAL_W-1:0] velocity_coef;
      logic signed [VAL_W-1:0] position_coef;
      logic signed [VAL_W-1:0] time_step;
      logic [DELAY_W-1:0]      delay_ticks;
      logic [TICK_W-1:0]       goal_start_tick;
   } cfg_type;

   // One finished Euler tick on its way to the metrics stage.
   typedef struct packed {
      logic                    valid;
      logic                    new_run;
      logic                    goal_on;
      logic [TICK_W-1:0]       tick;
      logic signed [VAL_W-1:0] position;
   } tick_rec_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] position;
      logic                    goal_level;
      logic [TICK_W-1:0]       tick_index;
      logic                    unstable;
      logic [DEV_W-1:0]        max_deviation;
      logic                    settled;
      logic [TICK_W-1:0]       settle_tick;
   } rsp_type;

endpackage
`default_nettype wire

// ===== rtl/core/dfps_csr.sv =====
// Configuration register file behind the APB-style port.
`default_nettype none
module dfps_csr
   import dfps_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [ADDR_W-1:0] paddr,
   input  wire logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0]      prdata,
   output logic                   pready,
   output cfg_type                cfg,
   output logic                   delay_wr
);

   cfg_type       cfg_ff, cfg_in;
   reg_index_type idx;
   logic          wr_en;

   assign pready = 1'b1;
   assign idx    = reg_index_type'(paddr[ADDR_W-1:2]);
   assign wr_en  = psel && penable && pwrite && pready;
   assign cfg    = cfg_ff;
   assign delay_wr = wr_en && (idx == REG_DELAY_TICKS);

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            REG_LOOP_GAIN:     cfg_in.loop_gain       = $signed(pwdata);
            REG_VELOCITY_COEF: cfg_in.velocity_coef   = $signed(pwdata);
            REG_POSITION_COEF: cfg_in.position_coef   = $signed(pwdata);
            REG_TIME_STEP:     cfg_in.time_step       = $signed(pwdata);
            REG_DELAY_TICKS:   cfg_in.delay_ticks     = pwdata[DELAY_W-1:0];
            REG_GOAL_START:    cfg_in.goal_start_tick = pwdata[TICK_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_LOOP_GAIN:     prdata = cfg_ff.loop_gain;
         REG_VELOCITY_COEF: prdata = cfg_ff.velocity_coef;
         REG_POSITION_COEF: prdata = cfg_ff.position_coef;
         REG_TIME_STEP:     prdata = cfg_ff.time_step;
         REG_DELAY_TICKS:   prdata = DATA_W'(cfg_ff.delay_ticks);
         REG_GOAL_START:    prdata = DATA_W'(cfg_ff.goal_start_tick);
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.loop_gain       <= RST_LOOP_GAIN;
         cfg_ff.velocity_coef   <= RST_VELOCITY_COEF;
         cfg_ff.position_coef   <= RST_POSITION_COEF;
         cfg_ff.time_step       <= RST_TIME_STEP;
         cfg_ff.delay_ticks     <= RST_DELAY_TICKS;
         cfg_ff.goal_start_tick <= RST_GOAL_START;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/dfps_ring.sv =====
// Position history ring: one write port, one registered read port.
`default_nettype none
module dfps_ring
   import dfps_pkg::*;
#(
   parameter int DEPTH = 256,
   parameter int WIDTH = 32,
   parameter int AW    = 8
)(
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0]      rd_data_ff
);

   logic [WIDTH-1:0] ring_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= ring_mem[rd_addr];
   end

endmodule
`default_nettype wire

// ===== rtl/core/dfps_calc.sv =====
// Tick sequencing, ring addressing and the two-stage Euler update.
`default_nettype none
module dfps_calc
   import dfps_pkg::*;
#(
   parameter int DELAY_DEPTH = 256,
   parameter int AW          = 8,
   parameter int EFF_W       = 32
)(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic             req_new_run,
   output logic                  req_stall,
   input  wire cfg_type          cfg,
   input  wire logic             delay_wr,
   input  wire logic [1:0]       fifo_count,
   output logic                  mem_wr_en,
   output logic [AW-1:0]         mem_wr_addr,
   output logic [EFF_W-1:0]      mem_wr_data,
   output logic [AW-1:0]         mem_rd_addr,
   input  wire logic [EFF_W-1:0] mem_rd_data,
   output tick_rec_type          rec
);

   localparam int PG_W  = 2 * VAL_W + 1;
   localparam int PP_W  = 2 * VAL_W;
   localparam int SUM_W = VAL_W + 12;
   localparam int TAB_N = 2 ** DELAY_W;
   localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'((64'sd1 <<< (EFF_W - 1)) - 64'sd1);
   localparam logic signed [SUM_W-1:0] SAT_MIN = -SAT_MAX - SUM_W'(1);
   localparam logic [AW-1:0]           WRAP_AT = AW'(DELAY_DEPTH - 1);

   typedef logic [AW-1:0] dmod_tab_type [TAB_N];

   function automatic dmod_tab_type build_dmod();
      dmod_tab_type t;
      for (int j = 0; j < TAB_N; j++) begin
         t[j] = AW'(j % DELAY_DEPTH);
      end
      return t;
   endfunction

   localparam dmod_tab_type DMOD = build_dmod();

   function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] r;
      r = v;
      if (v > SAT_MAX) r = SAT_MAX;
      if (v < SAT_MIN) r = SAT_MIN;
      return VAL_W'(r);
   endfunction

   // run state
   logic [TICK_W-1:0]       tick_ff, tick_in;
   logic [AW-1:0]           wp_ff, wp_in;
   logic signed [VAL_W-1:0] pos_ff, pos_in;
   logic signed [VAL_W-1:0] vel_ff, vel_in;
   logic                    rd_fresh_ff, rd_fresh_in;

   // first stage: products
   logic                    s1_valid_ff, s1_valid_in;
   logic                    s1_new_run_ff, s1_goal_ff;
   logic [TICK_W-1:0]       s1_tick_ff;
   logic signed [VAL_W-1:0] s1_pos_ff, s1_vel_ff;
   logic signed [PG_W-1:0]  pg_ff, pg_in;
   logic signed [PP_W-1:0]  pv_ff, pv_in, px_ff, px_in, pd_ff, pd_in;

   tick_rec_type            rec_ff, rec_in;

   logic                    accept;
   logic [1:0]              in_flight;
   logic [TICK_W-1:0]       tick_i;
   logic [AW-1:0]           wa, dm;
   logic [AW:0]             rdiff, rwrap;
   logic                    tick_last, goal_on;
   logic signed [VAL_W-1:0] pos_cur, vel_cur, x_del;
   logic signed [VAL_W:0]   err;
   logic signed [SUM_W-1:0] vsum, xsum;

   // a tick is accepted only while at most one other is in the stages or the
   // output queue, so the second stage never waits on the output queue
   assign in_flight = 2'(s1_valid_ff) + 2'(rec_ff.valid) + fifo_count;
   assign req_stall = !(rd_fresh_ff && (in_flight <= 2'd1));
   assign accept    = req_valid && !req_stall;

   assign tick_i    = req_new_run ? '0 : tick_ff;
   assign wa        = req_new_run ? '0 : wp_ff;
   assign tick_last = (tick_i == TICK_MAX);
   assign pos_cur   = req_new_run ? '0 : pos_ff;
   assign vel_cur   = req_new_run ? '0 : vel_ff;

   // delayed read address for the next tick, fetched ahead of it
   assign dm    = DMOD[cfg.delay_ticks];
   assign rdiff = {1'b0, wp_ff} - {1'b0, dm};
   assign rwrap = rdiff + (AW+1)'(DELAY_DEPTH);
   assign mem_rd_addr = rdiff[AW] ? rwrap[AW-1:0] : rdiff[AW-1:0];

   assign mem_wr_en   = accept;
   assign mem_wr_addr = wa;
   assign mem_wr_data = pos_cur[EFF_W-1:0];

   always_comb begin
      if (req_new_run || (tick_ff < TICK_W'(cfg.delay_ticks))) begin
         x_del = '0;
      end else if (dm == '0) begin
         x_del = pos_ff;  // delay lands on the entry written this tick
      end else begin
         x_del = VAL_W'($signed(mem_rd_data));
      end
   end

   assign goal_on = (tick_i >= cfg.goal_start_tick);
   assign err     = (goal_on ? (VAL_W+1)'(Q_ONE) : '0) - (VAL_W+1)'(x_del);

   assign pg_in = PG_W'(cfg.loop_gain) * PG_W'(err);
   assign pv_in = PP_W'(cfg.velocity_coef) * PP_W'(vel_cur);
   assign px_in = PP_W'(cfg.position_coef) * PP_W'(pos_cur);
   assign pd_in = PP_W'(cfg.time_step) * PP_W'(vel_cur);

   always_comb begin
      tick_in     = tick_ff;
      wp_in       = wp_ff;
      rd_fresh_in = !(accept || delay_wr);
      s1_valid_in = accept;
      if (accept) begin
         tick_in = tick_last ? tick_i : tick_i + TICK_W'(1);
         if (tick_last) begin
            wp_in = wa;
         end else begin
            wp_in = (wa == WRAP_AT) ? '0 : wa + AW'(1);
         end
      end
   end

   // second stage: floor-shifted sums and saturation
   assign vsum = SUM_W'(s1_vel_ff) + SUM_W'(pg_ff >>> FRAC_BITS)
               - SUM_W'(pv_ff >>> FRAC_BITS) - SUM_W'(px_ff >>> FRAC_BITS);
   assign xsum = SUM_W'(s1_pos_ff) + SUM_W'(pd_ff >>> FRAC_BITS);

   always_comb begin
      pos_in = pos_ff;
      vel_in = vel_ff;
      if (s1_valid_ff) begin
         pos_in = sat_val(xsum);
         vel_in = sat_val(vsum);
      end
      rec_in          = rec_ff;
      rec_in.valid    = s1_valid_ff;
      rec_in.new_run  = s1_new_run_ff;
      rec_in.goal_on  = s1_goal_ff;
      rec_in.tick     = s1_tick_ff;
      rec_in.position = sat_val(xsum);
   end

   assign rec = rec_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff      <= '0;
         wp_ff        <= '0;
         pos_ff       <= '0;
         vel_ff       <= '0;
         rd_fresh_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rec_ff.valid <= 1'b0;
      end else begin
         tick_ff      <= tick_in;
         wp_ff        <= wp_in;
         pos_ff       <= pos_in;
         vel_ff       <= vel_in;
         rd_fresh_ff  <= rd_fresh_in;
         s1_valid_ff  <= s1_valid_in;
         rec_ff       <= rec_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_new_run_ff <= req_new_run;
         s1_goal_ff    <= goal_on;
         s1_tick_ff    <= tick_i;
         s1_pos_ff     <= pos_cur;
         s1_vel_ff     <= vel_cur;
         pg_ff         <= pg_in;
         pv_ff         <= pv_in;
         px_ff         <= px_in;
         pd_ff         <= pd_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/dfps_track.sv =====
// Run metrics (stability, peak deviation, settling) and the result queue.
`default_nettype none
module dfps_track
   import dfps_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire tick_rec_type rec,
   input  wire logic         rsp_stall,
   output logic              rsp_valid,
   output rsp_type           rsp,
   output logic [1:0]        fifo_count
);

   logic              unst_ff, unst_in;
   logic [DEV_W-1:0]  peak_ff, peak_in;
   logic              set_ff, set_in;
   logic [TICK_W-1:0] set_at_ff, set_at_in;

   rsp_type           slot0_ff, slot1_ff, entry;
   logic              wr_ptr_ff, rd_ptr_ff;
   logic [1:0]        count_ff, count_in;
   logic              push, pop;

   logic              b_unst, b_set, big;
   logic [DEV_W-1:0]  b_peak, dev;
   logic [TICK_W-1:0] b_set_at;
   logic signed [VAL_W:0] dsig, dabs;

   // a new run starts from cleared metrics
   assign b_unst   = rec.new_run ? 1'b0 : unst_ff;
   assign b_peak   = rec.new_run ? '0 : peak_ff;
   assign b_set    = rec.new_run ? 1'b0 : set_ff;
   assign b_set_at = rec.new_run ? '0 : set_at_ff;

   assign big  = (rec.position > Q_ONE) || (rec.position < -Q_ONE);
   assign dsig = (VAL_W+1)'(rec.position) - (VAL_W+1)'(Q_ONE);
   assign dabs = dsig[VAL_W] ? -dsig : dsig;
   assign dev  = (dabs > (VAL_W+1)'(DEV_MAX)) ? DEV_MAX : dabs[DEV_W-1:0];

   always_comb begin
      unst_in   = unst_ff;
      peak_in   = peak_ff;
      set_in    = set_ff;
      set_at_in = set_at_ff;
      if (rec.valid) begin
         unst_in   = b_unst;
         peak_in   = b_peak;
         set_in    = b_set;
         set_at_in = b_set_at;
         if (!b_unst) begin
            if (big) begin
               unst_in = 1'b1;  // metrics freeze from this tick on
            end else begin
               if (dev > b_peak) peak_in = dev;
               if (!b_set && (dev <= SETTLE_BAND)) begin
                  set_in    = 1'b1;
                  set_at_in = rec.tick;
               end
            end
         end
      end
   end

   always_comb begin
      entry.position      = rec.position;
      entry.goal_level    = rec.goal_on;
      entry.tick_index    = rec.tick;
      entry.unstable      = unst_in;
      entry.max_deviation = peak_in;
      entry.settled       = set_in;
      entry.settle_tick   = set_at_in;
   end

   assign push       = rec.valid;
   assign rsp_valid  = (count_ff != 2'd0);
   assign pop        = rsp_valid && !rsp_stall;
   assign rsp        = rd_ptr_ff ? slot1_ff : slot0_ff;
   assign fifo_count = count_ff;
   assign count_in   = count_ff + 2'(push) - 2'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         unst_ff   <= 1'b0;
         peak_ff   <= '0;
         set_ff    <= 1'b0;
         set_at_ff <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         unst_ff   <= unst_in;
         peak_ff   <= peak_in;
         set_ff    <= set_in;
         set_at_ff <= set_at_in;
         count_ff  <= count_in;
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop)  rd_ptr_ff <= !rd_ptr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (push && !wr_ptr_ff) slot0_ff <= entry;
      if (push && wr_ptr_ff)  slot1_ff <= entry;
   end

endmodule
`default_nettype wire

// ===== rtl/core/delayed_feedback_plant_step_top.sv =====
// Top level of the delayed feedback plant step block.
//
// Each accepted req beat advances a second-order plant under delayed
// proportional control by one forward-Euler tick and yields one rsp beat
// with the new position and the run metrics. The block stalls after each
// accepted beat: the delayed position is fetched from the history ring
// ahead of the beat (single registered read port); the position/velocity
// update runs as a multiply stage, then an add-and-saturate stage. A result
// passes the product registers, the tick record and a two-entry output
// queue that lets the next beat in while a result waits. The ring needs no
// clearing after reset; the block stalls until its first ring read is
// registered. The user must write configuration over the APB-style port
// only while no beat is in flight; the block itself does not enforce this.
`default_nettype none
module delayed_feedback_plant_step_top
   import dfps_pkg::*;
#(
   parameter int DELAY_DEPTH = 256,
   parameter int VALUE_WIDTH = 32
)(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic                    req_new_run,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic signed [VAL_W-1:0]      rsp_position,
   output logic                         rsp_goal_level,
   output logic [TICK_W-1:0]            rsp_tick_index,
   output logic                         rsp_unstable,
   output logic [DEV_W-1:0]             rsp_max_deviation,
   output logic                         rsp_settled,
   output logic [TICK_W-1:0]            rsp_settle_tick,
   input  wire logic                    psel,
   input  wire logic                    penable,
   input  wire logic                    pwrite,
   input  wire logic [ADDR_W-1:0]       paddr,
   input  wire logic [DATA_W-1:0]       pwdata,
   output logic [DATA_W-1:0]            prdata,
   output logic                         pready
);

   localparam int AW    = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
   localparam int EFF_W = (VALUE_WIDTH < VAL_W) ? VALUE_WIDTH : VAL_W;

   cfg_type          cfg;
   logic             delay_wr;
   logic [1:0]       fifo_count;
   logic             mem_wr_en;
   logic [AW-1:0]    mem_wr_addr, mem_rd_addr;
   logic [EFF_W-1:0] mem_wr_data, mem_rd_data;
   tick_rec_type     rec;
   rsp_type          rsp;

   dfps_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready),
      .cfg      (cfg),
      .delay_wr (delay_wr)
   );

   dfps_ring #(
      .DEPTH (DELAY_DEPTH),
      .WIDTH (EFF_W),
      .AW    (AW)
   ) u_ring (
      .clock      (clock),
      .wr_en      (mem_wr_en),
      .wr_addr    (mem_wr_addr),
      .wr_data    (mem_wr_data),
      .rd_addr    (mem_rd_addr),
      .rd_data_ff (mem_rd_data)
   );

   dfps_calc #(
      .DELAY_DEPTH (DELAY_DEPTH),
      .AW          (AW),
      .EFF_W       (EFF_W)
   ) u_calc (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_new_run (req_new_run),
      .req_stall   (req_stall),
      .cfg         (cfg),
      .delay_wr    (delay_wr),
      .fifo_count  (fifo_count),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .rec         (rec)
   );

   dfps_track u_track (
      .clock      (clock),
      .reset      (reset),
      .rec        (rec),
      .rsp_stall  (rsp_stall),
      .rsp_valid  (rsp_valid),
      .rsp        (rsp),
      .fifo_count (fifo_count)
   );

   assign rsp_position      = rsp.position;
   assign rsp_goal_level    = rsp.goal_level;
   assign rsp_tick_index    = rsp.tick_index;
   assign rsp_unstable      = rsp.unstable;
   assign rsp_max_deviation = rsp.max_deviation;
   assign rsp_settled       = rsp.settled;
   assign rsp_settle_tick   = rsp.settle_tick;

endmodule
`default_nettype wire

// ===== rtl/core/dfps_checker.sv =====
// Port-level checks for the plant step top level, bound to it.
`default_nettype none
`include "delayed_feedback_plant_step_top_assert.svh"
module dfps_checker
   import dfps_pkg::*;
(
   input wire logic                    clock,
   input wire logic                    reset,
   input wire logic                    req_valid,
   input wire logic                    req_stall,
   input wire logic                    rsp_valid,
   input wire logic                    rsp_stall,
   input wire logic signed [VAL_W-1:0] rsp_position,
   input wire logic [TICK_W-1:0]       rsp_tick_index,
   input wire logic                    rsp_settled,
   input wire logic [TICK_W-1:0]       rsp_settle_tick
);

   // a beat is never followed by another in the very next cycle
   `DFPS_ASSERT_NEXT(a_beat_spacing, clock, reset, req_valid && !req_stall, req_stall)
   `DFPS_ASSERT_NOW(a_settle_zero, clock, reset, rsp_valid && !rsp_settled, rsp_settle_tick == '0)
   `DFPS_ASSERT_NOW(a_settle_order, clock, reset, rsp_valid && rsp_settled, rsp_settle_tick <= rsp_tick_index)
   `DFPS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_position) && $stable(rsp_tick_index))

endmodule

bind delayed_feedback_plant_step_top dfps_checker u_dfps_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_position    (rsp_position),
   .rsp_tick_index  (rsp_tick_index),
   .rsp_settled     (rsp_settled),
   .rsp_settle_tick (rsp_settle_tick)
);
`default_nettype wire

// ===== tb/sv/tb_delayed_feedback_plant_step_top.sv =====
// Self-checking testbench for the delayed feedback plant step block.
`default_nettype none
module tb_delayed_feedback_plant_step_top;
   import dfps_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int                RING_DEPTH    = 256;
   localparam longint            VAL_HI        = 64'sd2147483647;
   localparam longint            VAL_LO        = -64'sd2147483648;
   localparam logic [ADDR_W-1:0] UNMAPPED_ADDR = 5'd24;
   localparam int                DRAIN_LIMIT   = 2000;
   localparam int                SHOW_LIMIT    = 100;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic                    req_new_run = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic signed [VAL_W-1:0] rsp_position;
   logic                    rsp_goal_level;
   logic [TICK_W-1:0]       rsp_tick_index;
   logic                    rsp_unstable;
   logic [DEV_W-1:0]        rsp_max_deviation;
   logic                    rsp_settled;
   logic [TICK_W-1:0]       rsp_settle_tick;
   logic                    psel = 1'b0;
   logic                    penable = 1'b0;
   logic                    pwrite = 1'b0;
   logic [ADDR_W-1:0]       paddr = '0;
   logic [DATA_W-1:0]       pwdata = '0;
   logic [DATA_W-1:0]       prdata;
   logic                    pready;

   delayed_feedback_plant_step_top i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_new_run       (req_new_run),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_position      (rsp_position),
      .rsp_goal_level    (rsp_goal_level),
      .rsp_tick_index    (rsp_tick_index),
      .rsp_unstable      (rsp_unstable),
      .rsp_max_deviation (rsp_max_deviation),
      .rsp_settled       (rsp_settled),
      .rsp_settle_tick   (rsp_settle_tick),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin : watchdog
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

   // plant model state and register shadows
   logic signed [VAL_W-1:0] history [RING_DEPTH];
   longint                  pos_q, vel_q, peak_q;
   int unsigned             tick_q, settle_at_q;
   bit                      unstable_q, settled_q;
   logic signed [VAL_W-1:0] gain_q, vdamp_q, pstiff_q, dt_q;
   int unsigned             delay_q, goal_start_q;

   rsp_type tick_results [$];
   int      fail_count = 0;
   int      shown = 0;
   bit      tx_gaps_on = 1'b1;
   bit      rx_stall_on = 1'b1;
   int      hold_ask = 0;

   function automatic void queue_expected(rsp_type want);
      tick_results.insert(tick_results.size(), want);
   endfunction

   function automatic longint sat_q824(longint v);
      if (v > VAL_HI) return VAL_HI;
      if (v < VAL_LO) return VAL_LO;
      return v;
   endfunction

   function automatic rsp_type advance_plant(bit new_run);
      rsp_type     want;
      int unsigned i;
      longint      x_del, err, v_new, x_new, dev;
      bit          goal_on;
      if (new_run) begin
         pos_q       = 0;
         vel_q       = 0;
         tick_q      = 0;
         unstable_q  = 1'b0;
         peak_q      = 0;
         settled_q   = 1'b0;
         settle_at_q = 0;
      end
      i = tick_q;
      history[i % RING_DEPTH] = pos_q[VAL_W-1:0];
      x_del = (i >= delay_q) ? longint'(history[(i - delay_q) % RING_DEPTH]) : 0;
      goal_on = i >= goal_start_q;
      err = (goal_on ? longint'(Q_ONE) : 0) - x_del;
      // products are exact in 64 bits, >>> on a signed longint floors
      v_new = vel_q + ((longint'(gain_q) * err) >>> FRAC_BITS)
              - ((longint'(vdamp_q) * vel_q) >>> FRAC_BITS)
              - ((longint'(pstiff_q) * pos_q) >>> FRAC_BITS);
      x_new = pos_q + ((longint'(dt_q) * vel_q) >>> FRAC_BITS);
      vel_q = sat_q824(v_new);
      pos_q = sat_q824(x_new);
      if (!unstable_q) begin
         if (pos_q > longint'(Q_ONE) || pos_q < -longint'(Q_ONE)) begin
            unstable_q = 1'b1;
         end else begin
            dev = pos_q - longint'(Q_ONE);
            if (dev < 0) dev = -dev;
            if (dev > longint'(DEV_MAX)) dev = longint'(DEV_MAX);
            if (dev > peak_q) peak_q = dev;
            if (!settled_q && dev <= longint'(SETTLE_BAND)) begin
               settled_q   = 1'b1;
               settle_at_q = i;
            end
         end
      end
      if (tick_q < TICK_MAX) tick_q++;
      want.position      = pos_q[VAL_W-1:0];
      want.goal_level    = goal_on;
      want.tick_index    = i[TICK_W-1:0];
      want.unstable      = unstable_q;
      want.max_deviation = peak_q[DEV_W-1:0];
      want.settled       = settled_q;
      want.settle_tick   = settle_at_q[TICK_W-1:0];
      return want;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
      fail_count++;
      if (shown < SHOW_LIMIT) begin
         shown++;
         $display("%0t: %s expected %h actual %h", $time, what, want, got);
      end
   endtask

   task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
      if (want !== got) report_mismatch(what, want, got);
   endtask

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (tick_results.size() == 0) begin
            report_mismatch("unexpected beat, position", 'x, rsp_position);
         end else begin
            want = tick_results.pop_front();
            check_field("position", want.position, rsp_position);
            check_field("goal_level", want.goal_level, rsp_goal_level);
            check_field("tick_index", want.tick_index, rsp_tick_index);
            check_field("unstable", want.unstable, rsp_unstable);
            check_field("max_deviation", want.max_deviation, rsp_max_deviation);
            check_field("settled", want.settled, rsp_settled);
            check_field("settle_tick", want.settle_tick, rsp_settle_tick);
         end
      end
   end

   // receiver: random stall bursts plus long holds on request
   initial begin : rsp_side
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (hold_ask > 0) begin
            stall_left = hold_ask;
            hold_ask   = 0;
         end else if (stall_left == 0 && rx_stall_on && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 7);
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_tick(bit new_run);
      req_valid   <= 1'b1;
      req_new_run <= new_run;
      do @(posedge clock); while (!(req_valid && !req_stall));
      queue_expected(advance_plant(new_run));
      if (tx_gaps_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
   endtask

   task automatic drain();
      int waited;
      req_valid <= 1'b0;
      waited = 0;
      while (tick_results.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (tick_results.size() != 0) begin
         fail_count++;
         $display("%0t: %0d expected beats never arrived", $time, tick_results.size());
         tick_results.delete();
      end
      repeat (6) @(posedge clock);
   endtask

   task automatic csr_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_read(reg_index_type idx, logic [DATA_W-1:0] want);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {idx, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      check_field(idx.name(), want, prdata);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_reg(reg_index_type idx, logic [DATA_W-1:0] value);
      logic [DATA_W-1:0] kept;
      kept = value;
      case (idx)
         REG_LOOP_GAIN:     gain_q   = value;
         REG_VELOCITY_COEF: vdamp_q  = value;
         REG_POSITION_COEF: pstiff_q = value;
         REG_TIME_STEP:     dt_q     = value;
         REG_DELAY_TICKS: begin
            kept    = {24'd0, value[DELAY_W-1:0]};
            delay_q = kept;
         end
         REG_GOAL_START: begin
            kept         = {16'd0, value[TICK_W-1:0]};
            goal_start_q = kept;
         end
         default: ;
      endcase
      csr_write({idx, 2'b00}, value);
      csr_read(idx, kept);
   endtask

   // narrow registers get junk in the upper bits to show they are dropped
   task automatic set_plant(logic [31:0] gain, logic [31:0] vdamp, logic [31:0] pstiff,
                            logic [31:0] dt, int unsigned delay, int unsigned goal_start);
      set_reg(REG_LOOP_GAIN, gain);
      set_reg(REG_VELOCITY_COEF, vdamp);
      set_reg(REG_POSITION_COEF, pstiff);
      set_reg(REG_TIME_STEP, dt);
      set_reg(REG_DELAY_TICKS, ($urandom() & 32'hFFFF_FF00) | delay);
      set_reg(REG_GOAL_START, ($urandom() & 32'hFFFF_0000) | goal_start);
   endtask

   task automatic random_config(bit wild);
      if (wild)
         set_plant($urandom(), $urandom(), $urandom(), $urandom(), $urandom_range(0, 255),
                   $urandom_range(0, 1) ? $urandom_range(0, 65535) : $urandom_range(0, 30));
      else
         set_plant($urandom_range(0, 32'h0200_0000), $urandom_range(0, 32'h0100_0000),
                   $urandom_range(0, 32'h0080_0000),
                   $urandom_range(32'h0010_0000, 32'h0100_0000),
                   $urandom_range(0, 20), $urandom_range(0, 15));
   endtask

   task automatic test_reset_defaults();
      gain_q       = RST_LOOP_GAIN;
      vdamp_q      = RST_VELOCITY_COEF;
      pstiff_q     = RST_POSITION_COEF;
      dt_q         = RST_TIME_STEP;
      delay_q      = 32'(RST_DELAY_TICKS);
      goal_start_q = 32'(RST_GOAL_START);
      pos_q = 0; vel_q = 0; tick_q = 0; peak_q = 0;
      unstable_q = 1'b0; settled_q = 1'b0; settle_at_q = 0;
      csr_read(REG_LOOP_GAIN, RST_LOOP_GAIN);
      csr_read(REG_VELOCITY_COEF, RST_VELOCITY_COEF);
      csr_read(REG_POSITION_COEF, RST_POSITION_COEF);
      csr_read(REG_TIME_STEP, RST_TIME_STEP);
      csr_read(REG_DELAY_TICKS, {24'd0, RST_DELAY_TICKS});
      csr_read(REG_GOAL_START, {16'd0, RST_GOAL_START});
      // state straight out of reset, goal and delay both kick in at tick 10
      repeat (11) send_tick(1'b0);
      drain();
   endtask

   task automatic test_settling();
      // unit gain, no delay: lands on 1.0 at tick 1, overshoots to 2.0 at tick 2
      set_plant(Q_ONE, Q_ONE, 32'd0, Q_ONE, 0, 0);
      send_tick(1'b1);
      repeat (3) send_tick(1'b0);
      drain();
      // edge of the settling band, then just outside it
      set_reg(REG_LOOP_GAIN, Q_ONE - SETTLE_BAND);
      send_tick(1'b1);
      repeat (2) send_tick(1'b0);
      drain();
      set_reg(REG_LOOP_GAIN, Q_ONE - SETTLE_BAND - 1);
      send_tick(1'b1);
      repeat (2) send_tick(1'b0);
      drain();
   endtask

   task automatic test_extremes();
      set_plant(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 255, 0);
      // out-of-map write must leave every register alone
      csr_write(UNMAPPED_ADDR, 32'hFFFF_FFFF);
      csr_read(REG_LOOP_GAIN, 32'h7FFF_FFFF);
      send_tick(1'b1);
      repeat (2) send_tick(1'b0);
      drain();
      set_plant(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1, 65535);
      send_tick(1'b1);
      repeat (2) send_tick(1'b0);
      drain();
   endtask

   task automatic test_random_runs();
      int sent, run_len;
      tx_gaps_on  = 1'b1;
      rx_stall_on = 1'b1;
      sent = 0;
      while (sent < 380) begin
         drain();
         random_config($urandom_range(0, 3) == 0);
         repeat ($urandom_range(1, 3)) begin
            run_len = $urandom_range(5, 50);
            send_tick($urandom_range(0, 9) != 0);
            repeat (run_len) send_tick($urandom_range(0, 29) == 0);
            sent += run_len + 1;
         end
      end
      drain();
   endtask

   task automatic test_backpressure();
      tx_gaps_on  = 1'b0;
      rx_stall_on = 1'b0;
      random_config(1'b0);
      hold_ask = 60;
      send_tick(1'b1);
      repeat (15) send_tick(1'b0);
      drain();
   endtask

   task automatic test_quiet_tail();
      tx_gaps_on  = 1'b0;
      rx_stall_on = 1'b0;
      random_config(1'b0);
      send_tick(1'b1);
      repeat (39) send_tick(1'b0);
      drain();
   endtask

   initial begin : run_tests
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_settling();
      test_extremes();
      test_random_runs();
      test_backpressure();
      test_quiet_tail();
      repeat (10) @(posedge clock);
      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
`default_nettype wire
